[design/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants, types and helpers for the qrs threshold detector
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int RR_DEPTH_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 20;

  localparam int LEVEL_BITS = 24;
  localparam int LEVEL_FRAC = 6;
  localparam int LIMIT_FRAC = 8;
  localparam int LEARN_W    = 13;
  localparam int TIMEOUT_W  = 20;
  localparam int LIMIT_W    = 10;
  localparam int IVL_W      = 20;
  localparam int CFG_DATA_W = 20;
  localparam int SEED_W     = 28;

  localparam logic [1:0] CFG_LEARN   = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_LOWER   = 2'd2;
  localparam logic [1:0] CFG_UPPER   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_SEED_TEN,
    ST_SEED_FIN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic             r_peak;
    logic             found_by_search;
    logic [IVL_W-1:0] beat_interval;
    logic             learning;
  } result_t;

  // saturate a wide signed value to the level width
  function automatic logic signed [LEVEL_BITS-1:0] sat_level(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd8388607;
    lo = -48'sd8388608;
    if (v > hi) sat_level = hi[LEVEL_BITS-1:0];
    else if (v < lo) sat_level = lo[LEVEL_BITS-1:0];
    else sat_level = v[LEVEL_BITS-1:0];
  endfunction

  // level + floor((target - level) / 2^k), saturated
  function automatic logic signed [LEVEL_BITS-1:0] blend(
    input logic signed [LEVEL_BITS-1:0] level,
    input logic signed [LEVEL_BITS-1:0] target,
    input int k
  );
    logic signed [47:0] d;
    d = 48'(target) - 48'(level);
    blend = sat_level(48'(level) + (d >>> k));
  endfunction

endpackage

[design/qrs_adaptive_threshold_detector_top.sv]
// ----------------------------------------------------------------------------
// qrs_adaptive_threshold_detector_top
// qrs decision rules: seeding, adaptive thresholds, rr ring and search back
// ----------------------------------------------------------------------------
// a pushed sample waits in the input queue until the idle back takes it;
//   the decide and emit steps follow, and emit stalls while the result
//   queue is full; no new sample is taken before emit; the beat that closes
//   seeding also runs the bit-serial seed divider and the tenth step
// reset: synchronous active low, clears queues and detector state and loads
//   the register defaults; no clearing pass
// ----------------------------------------------------------------------------
module qrs_adaptive_threshold_detector_top #(
  parameter int RR_DEPTH    = qrs_pkg::RR_DEPTH_DEF,
  parameter int SAMPLE_BITS = qrs_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = qrs_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_idx,
  input  logic [qrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_r_peak,
  output logic                           out_found_by_search,
  output logic [qrs_pkg::IVL_W-1:0]      out_beat_interval,
  output logic                           out_learning
);

  // front: sample queue takes beats while the back is busy
  logic q_valid, q_take;
  logic [SAMPLE_BITS-1:0] q_data;
  qrs_in_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_inq (
    .clk(clk), .rst_n(rst_n), .wr_en(push && !full), .wr_data(in_sample),
    .full(full), .rd_en(q_take), .rd_valid(q_valid), .rd_data(q_data)
  );

  // back: decision sequencer
  logic res_wr, res_full;
  qrs_pkg::result_t res_data, out_data;
  qrs_back #(.RR_DEPTH(RR_DEPTH), .SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(q_valid), .in_data(q_data), .in_take(q_take),
    .res_full(res_full), .res_wr(res_wr), .res_data(res_data)
  );

  // result queue parts the back from the consumer
  qrs_out_queue u_outq (
    .clk(clk), .rst_n(rst_n), .wr_en(res_wr), .wr_data(res_data), .full(res_full),
    .pop(pop), .empty(empty), .rd_data(out_data)
  );

  assign out_r_peak          = out_data.r_peak;
  assign out_found_by_search = out_data.found_by_search;
  assign out_beat_interval   = out_data.beat_interval;
  assign out_learning        = out_data.learning;

endmodule

[design/qrs_in_queue.sv]
// ----------------------------------------------------------------------------
// qrs_in_queue
// two-entry sample queue between the accepting front and the decision back
// ----------------------------------------------------------------------------
module qrs_in_queue #(
  parameter int SAMPLE_BITS = qrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  output logic                   full,
  input  logic                   rd_en,
  output logic                   rd_valid,
  output logic [SAMPLE_BITS-1:0] rd_data
);

  logic [SAMPLE_BITS-1:0] mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign full     = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

endmodule

[design/qrs_out_queue.sv]
// ----------------------------------------------------------------------------
// qrs_out_queue
// two-entry result queue at the output
// ----------------------------------------------------------------------------
module qrs_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  qrs_pkg::result_t  wr_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output qrs_pkg::result_t  rd_data
);

  qrs_pkg::result_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       rd_en;

  assign rd_en = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign rd_data = mem_r[rp_r];

endmodule

[design/qrs_seed_div.sv]
// ----------------------------------------------------------------------------
// qrs_seed_div
// restoring divider, one quotient bit a cycle, signed dividend, truncating
// ----------------------------------------------------------------------------
module qrs_seed_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 13
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic             neg_r, busy_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [DEN_W:0]   trial;
  logic [NUM_W-1:0] mag;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= mag;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

[design/qrs_back.sv]
// ----------------------------------------------------------------------------
// qrs_back
// seeding, peak classification, adaptive levels and rr ring
// ----------------------------------------------------------------------------
module qrs_back #(
  parameter int RR_DEPTH    = qrs_pkg::RR_DEPTH_DEF,
  parameter int SAMPLE_BITS = qrs_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = qrs_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_idx,
  input  logic [qrs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic [SAMPLE_BITS-1:0]          in_data,
  output logic                            in_take,
  input  logic                            res_full,
  output logic                            res_wr,
  output qrs_pkg::result_t                res_data
);

  localparam int LB    = qrs_pkg::LEVEL_BITS;
  localparam int HW    = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;
  localparam int FW    = $clog2(RR_DEPTH + 1);
  localparam int TOT_W = COUNT_BITS + $clog2(RR_DEPTH + 1);
  localparam int SCL_W = $clog2(RR_DEPTH) + qrs_pkg::LIMIT_FRAC;
  localparam int NUM_W = qrs_pkg::SEED_W + qrs_pkg::LEVEL_FRAC;
  localparam int CMP_W = (COUNT_BITS > qrs_pkg::TIMEOUT_W) ? COUNT_BITS : qrs_pkg::TIMEOUT_W;
  localparam int IVC_W = (COUNT_BITS > qrs_pkg::IVL_W) ? COUNT_BITS : qrs_pkg::IVL_W;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [SCL_W:0] SCALE = (SCL_W+1)'(RR_DEPTH * 256);
  localparam logic [IVC_W-1:0] IVL_MAX = IVC_W'({qrs_pkg::IVL_W{1'b1}});
  // ceil(2^24 / 10), exact for magnitudes up to 2^21
  localparam logic [20:0] TEN_RECIP = 21'd1677722;

  // configuration
  logic [qrs_pkg::LEARN_W-1:0]   learn_r;
  logic [qrs_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [qrs_pkg::LIMIT_W-1:0]   lower_r, upper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_r   <= 13'd500;
      timeout_r <= 20'd1000;
      lower_r   <= 10'd128;
      upper_r   <= 10'd425;
    end else if (cfg_we) begin
      case (cfg_idx)
        qrs_pkg::CFG_LEARN:   learn_r   <= cfg_data[qrs_pkg::LEARN_W-1:0];
        qrs_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
        qrs_pkg::CFG_LOWER:   lower_r   <= cfg_data[qrs_pkg::LIMIT_W-1:0];
        qrs_pkg::CFG_UPPER:   upper_r   <= cfg_data[qrs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  qrs_pkg::back_state_t st_r, st_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_r, x_r;
  logic have_prev_r, rising_r, locked_r, seeding_r;
  logic signed [LB-1:0] sig_r, noise_r, th1_r, th2_r;
  logic [COUNT_BITS-1:0] since_c_r, since_p_r;
  logic [FW-1:0] filled_r;
  logic [COUNT_BITS-1:0] ring_r [RR_DEPTH];
  logic [HW-1:0] head_r;
  logic [TOT_W-1:0] total_r;
  logic signed [qrs_pkg::SEED_W-1:0] seed_sum_r;
  logic [qrs_pkg::LEARN_W-1:0] seed_nz_r, seed_idx_r;
  qrs_pkg::result_t res_r;

  // products registered when a sample is taken, ready for DECIDE (prep registers)
  logic [qrs_pkg::LIMIT_W+TOT_W-1:0] low_prod_r, up_prod_r;
  logic [COUNT_BITS+SCL_W:0]         cand_prod_r;

  // seeding arithmetic
  logic [qrs_pkg::LEARN_W-1:0] span, nz_next, idx_next;
  logic seed_end;
  logic signed [qrs_pkg::SEED_W-1:0] seed_sum_next;
  assign span     = (learn_r == '0) ? qrs_pkg::LEARN_W'(1) : learn_r;
  assign nz_next  = seed_nz_r + qrs_pkg::LEARN_W'(x_r != '0);
  assign idx_next = seed_idx_r + 1'b1;
  assign seed_end = idx_next >= span;
  // a zero sample adds nothing, so the sum takes every sample
  assign seed_sum_next = seed_sum_r + qrs_pkg::SEED_W'(x_r);

  // divider, started with the window's sum and nonzero count including this beat
  logic div_start, div_done;
  logic signed [NUM_W-1:0] div_quo;
  qrs_seed_div #(.NUM_W(NUM_W), .DEN_W(qrs_pkg::LEARN_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(NUM_W'(seed_sum_next) <<< qrs_pkg::LEVEL_FRAC), .den(nz_next),
    .done(div_done), .quo(div_quo)
  );

  logic signed [NUM_W-1:0] avg_r;
  always_ff @(posedge clk) if (div_done) avg_r <= div_quo;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      qrs_pkg::ST_IDLE:     if (in_valid) st_nxt = qrs_pkg::ST_DECIDE;
      qrs_pkg::ST_DECIDE:   st_nxt = qrs_pkg::ST_EMIT;
      qrs_pkg::ST_DIV:      if (div_done) st_nxt = qrs_pkg::ST_SEED_TEN;
      qrs_pkg::ST_SEED_TEN: st_nxt = qrs_pkg::ST_SEED_FIN;
      qrs_pkg::ST_SEED_FIN: st_nxt = qrs_pkg::ST_EMIT;
      qrs_pkg::ST_EMIT:     if (!res_full) st_nxt = qrs_pkg::ST_IDLE;
      default:              st_nxt = qrs_pkg::ST_IDLE;
    endcase
    if (st_r == qrs_pkg::ST_DECIDE && seeding_r && seed_end && nz_next != '0)
      st_nxt = qrs_pkg::ST_DIV;
  end

  // outputs
  always_comb begin
    in_take   = (st_r == qrs_pkg::ST_IDLE) && in_valid;
    res_wr    = (st_r == qrs_pkg::ST_EMIT) && !res_full;
    res_data  = res_r;
    div_start = (st_r == qrs_pkg::ST_DECIDE) && (st_nxt == qrs_pkg::ST_DIV);
  end

  // decision arithmetic
  logic signed [LB-1:0] pq;
  logic rise, peak, sig_hit, search_hit;
  assign pq   = LB'(prev_r) <<< qrs_pkg::LEVEL_FRAC;
  assign rise = rising_r || (prev_r <= x_r);
  assign peak = rise && (prev_r > x_r);
  assign sig_hit    = (pq >= th1_r) || (CMP_W'(since_c_r) > CMP_W'(timeout_r));
  assign search_hit = locked_r
                      && ((qrs_pkg::LIMIT_W+TOT_W)'(cand_prod_r) >= up_prod_r)
                      && (pq >= th2_r);

  function automatic logic [COUNT_BITS-1:0] cinc(input logic [COUNT_BITS-1:0] c);
    cinc = (c == CMAX) ? c : c + 1'b1;
  endfunction

  function automatic logic signed [LB-1:0] th1_of(input logic signed [LB-1:0] s,
                                                  input logic signed [LB-1:0] n);
    logic signed [47:0] d;
    d = 48'(s) - 48'(n);
    th1_of = qrs_pkg::sat_level(48'(n) + (d >>> 2));
  endfunction

  // tenth of the average by reciprocal multiplication, truncated toward zero
  logic              avg_neg;
  logic [22:0]       avg_mag;
  logic [43:0]       ten_prod;
  logic [19:0]       tenth_mag;
  logic signed [LB-1:0] tenth_r, seed_noise, seed_sig, t1_seed;
  assign avg_neg   = avg_r[NUM_W-1];
  assign avg_mag   = avg_neg ? 23'(-avg_r) : 23'(avg_r);
  assign ten_prod  = avg_mag * TEN_RECIP;
  assign tenth_mag = ten_prod[43:24];

  always_ff @(posedge clk) begin
    if (st_r == qrs_pkg::ST_SEED_TEN) tenth_r <= avg_neg ? -LB'(tenth_mag) : LB'(tenth_mag);
  end

  assign seed_noise = qrs_pkg::sat_level(48'(avg_r) - 48'(tenth_r));
  assign seed_sig   = qrs_pkg::sat_level(48'(avg_r) + 48'(tenth_r));
  assign t1_seed    = th1_of(seed_sig, seed_noise);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= qrs_pkg::ST_IDLE;
      have_prev_r <= 1'b0; rising_r <= 1'b1; locked_r <= 1'b0; seeding_r <= 1'b1;
      sig_r <= '0; noise_r <= '0; th1_r <= '0; th2_r <= '0;
      since_c_r <= '0; since_p_r <= '0; filled_r <= '0; head_r <= '0;
      total_r <= '0; seed_sum_r <= '0; seed_nz_r <= '0; seed_idx_r <= '0;
      prev_r <= '0;
      for (int i = 0; i < RR_DEPTH; i++) ring_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (in_take) begin
        x_r <= in_data;
        // multiplies happen here against registered state
        low_prod_r <= lower_r * total_r;
        up_prod_r  <= upper_r * total_r;
      end
      case (st_r)
        qrs_pkg::ST_DECIDE: begin : decide_st
          qrs_pkg::result_t rn;
          rn = '0;
          if (seeding_r) begin
            rn.learning = 1'b1;
            if (seed_end && nz_next == '0) begin
              noise_r <= '0; sig_r <= '0; th1_r <= '0; th2_r <= '0;
              seed_sum_r <= '0; seed_nz_r <= '0; seed_idx_r <= '0;
            end else begin
              seed_sum_r <= seed_sum_next;
              seed_nz_r  <= nz_next;
              seed_idx_r <= idx_next;
            end
          end else if (!have_prev_r) begin
            prev_r <= x_r;
            have_prev_r <= 1'b1;
          end else begin : dec
            logic [COUNT_BITS-1:0] sc, sp;
            logic [TOT_W-1:0] tot;
            logic lk, pub, bys;
            logic signed [LB-1:0] s, n;
            sc = since_c_r; sp = cinc(since_p_r); tot = total_r; lk = locked_r;
            pub = 1'b0; bys = 1'b0; s = sig_r; n = noise_r;
            if (peak) begin
              if (sig_hit) begin
                if (filled_r < FW'(RR_DEPTH)) begin
                  ring_r[filled_r[HW-1:0]] <= sc;
                  filled_r <= filled_r + 1'b1;
                  tot = tot + TOT_W'(sc);
                  sc = '0;
                  // low check used only when locked, and locked implies ring full
                end else begin
                  lk = 1'b1;
                end
                if (lk && (low_prod_r <= (qrs_pkg::LIMIT_W+TOT_W)'(cand_prod_r))) begin
                  tot = tot + TOT_W'(sc) - TOT_W'(ring_r[head_r]);
                  ring_r[head_r] <= sc;
                  head_r <= (head_r == HW'(RR_DEPTH-1)) ? '0 : head_r + 1'b1;
                  sc = '0;
                  pub = 1'b1;
                end else begin
                  sc = cinc(sc);
                end
                s = qrs_pkg::blend(sig_r, pq, 3);
              end else if (search_hit) begin
                n = qrs_pkg::blend(noise_r, pq, 2);
                sc = '0; pub = 1'b1; bys = 1'b1;
              end else begin
                n = qrs_pkg::blend(noise_r, pq, 3);
                sc = cinc(sc);
              end
              rising_r <= 1'b0;
            end else begin
              sc = cinc(sc);
              rising_r <= rise;
            end
            sig_r <= s; noise_r <= n;
            th1_r <= th1_of(s, n);
            th2_r <= th1_of(s, n) >>> 1;
            total_r <= tot; locked_r <= lk; since_c_r <= sc;
            if (pub) begin
              rn.r_peak = 1'b1;
              rn.found_by_search = bys;
              rn.beat_interval = (IVC_W'(sp) > IVL_MAX) ? qrs_pkg::IVL_W'(IVL_MAX)
                                                        : qrs_pkg::IVL_W'(sp);
              since_p_r <= '0;
            end else begin
              since_p_r <= sp;
            end
            prev_r <= x_r;
          end
          res_r <= rn;
        end
        qrs_pkg::ST_SEED_FIN: begin
          noise_r <= seed_noise;
          sig_r   <= seed_sig;
          th1_r   <= t1_seed;
          th2_r   <= t1_seed >>> 1;
          rising_r <= 1'b1; seeding_r <= 1'b0; have_prev_r <= 1'b0;
          seed_sum_r <= '0; seed_nz_r <= '0; seed_idx_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // candidate product uses since_candidate as held at acceptance
  always_ff @(posedge clk) begin
    if (in_take) cand_prod_r <= since_c_r * SCALE;
  end

endmodule

[design/qrs_checker.sv]
// ----------------------------------------------------------------------------
// qrs_checker
// port-level checks on the detector
// ----------------------------------------------------------------------------
module qrs_checker (
  input logic clk,
  input logic rst_n,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic out_r_peak,
  input logic out_found_by_search,
  input logic out_learning,
  input logic [19:0] out_beat_interval
);

  a_search_implies_peak: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (!out_found_by_search || out_r_peak)) else $error("search without peak");

  a_learning_no_peak: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_learning |-> !out_r_peak) else $error("peak while learning");

  a_no_interval: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_r_peak |-> out_beat_interval == 20'd0) else $error("stray interval");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty && !full) else $error("queues not cleared");

endmodule

bind qrs_adaptive_threshold_detector_top qrs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
  .out_r_peak(out_r_peak), .out_found_by_search(out_found_by_search),
  .out_learning(out_learning), .out_beat_interval(out_beat_interval)
);
